// File: src/slt_pkg.sv
`default_nettype none
package slt_pkg;

    localparam logic [3:0] M_BETWEEN = 4'd0;
    localparam logic [3:0] M_WORD    = 4'd1;
    localparam logic [3:0] M_QUOTE   = 4'd2;
    localparam logic [3:0] M_ESC     = 4'd3;
    localparam logic [3:0] M_GT      = 4'd4;
    localparam logic [3:0] M_SKIP    = 4'd5;

    localparam logic [2:0] KIND_BYTE     = 3'd0;
    localparam logic [2:0] KIND_WORD_END = 3'd1;
    localparam logic [2:0] KIND_OPER     = 3'd2;
    localparam logic [2:0] KIND_LINE_END = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    localparam logic [2:0] OP_PIPE   = 3'd0;
    localparam logic [2:0] OP_IN     = 3'd1;
    localparam logic [2:0] OP_OUT    = 3'd2;
    localparam logic [2:0] OP_APPEND = 3'd3;
    localparam logic [2:0] OP_BG     = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_QUOTE    = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY = 2'd3;

    localparam logic CFG_MAX_TOKENS   = 1'b0;
    localparam logic CFG_MAX_WORD_LEN = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_value;
        logic [2:0] op_code;
        logic [6:0] token_index;
        logic [1:0] error_code;
        logic [7:0] token_count;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       res;
    } t_batch;

    function automatic t_res mk_res(input logic [2:0] kind, input logic [7:0] chv,
                                    input logic [2:0] op, input logic [6:0] idx,
                                    input logic [1:0] err, input logic [7:0] cnt);
        t_res r;
        r.kind        = kind;
        r.char_value  = chv;
        r.op_code     = op;
        r.token_index = idx;
        r.error_code  = err;
        r.token_count = cnt;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP;
    endfunction

endpackage
`default_nettype wire

// File: src/slt_lexer.sv
`default_nettype none
module slt_lexer
    import slt_pkg::*;
#(
    parameter int TOKEN_LIMIT = 128,
    parameter int WORD_BUFFER = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_ch,
    input  wire logic [7:0] i_max_tokens,
    input  wire logic [7:0] i_max_word_len,
    output t_batch          o_batch
);

    localparam int TS_W = $clog2(TOKEN_LIMIT + 1);
    localparam int WL_W = $clog2(WORD_BUFFER);
    localparam logic [7:0] TOK_MAX = 8'(TOKEN_LIMIT);
    localparam logic [7:0] LEN_MAX = 8'(WORD_BUFFER - 1);

    logic [3:0]      r_mode, n_mode;
    logic            r_qc, n_qc;
    logic [WL_W-1:0] r_wl, n_wl;
    logic [TS_W-1:0] r_ts, n_ts;
    logic [1:0]      r_err, n_err;

    logic [7:0]  tok_lim, len_lim, app_c;
    logic [1:0]  n;
    t_res [2:0]  res;
    logic        run_b, do_wb, do_app, do_we, do_le;

    function automatic logic [6:0] cur_idx(input logic [TS_W-1:0] ts);
        return (ts == '0) ? 7'd0 : 7'(ts - 1'b1);
    endfunction

    always_comb begin
        tok_lim = (i_max_tokens == 8'd0) ? 8'd1 : i_max_tokens;
        if (tok_lim > TOK_MAX) begin
            tok_lim = TOK_MAX;
        end
        len_lim = (i_max_word_len == 8'd0) ? 8'd1 : i_max_word_len;
        if (len_lim > LEN_MAX) begin
            len_lim = LEN_MAX;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_qc   = r_qc;
        n_wl   = r_wl;
        n_ts   = r_ts;
        n_err  = r_err;
        n      = 2'd0;
        res    = '0;
        run_b  = 1'b0;
        do_wb  = 1'b0;
        do_app = 1'b0;
        do_we  = 1'b0;
        do_le  = 1'b0;
        app_c  = i_ch;

        case (r_mode)
            M_WORD: begin
                if (i_ch == CH_NUL || is_space(i_ch) || is_oper(i_ch)) begin
                    res[n] = mk_res(KIND_WORD_END, 8'd0, OP_PIPE, cur_idx(n_ts), ERR_NONE,
                                    8'd0);
                    n      = n + 2'd1;
                    n_wl   = '0;
                    n_mode = M_BETWEEN;
                    do_le  = (i_ch == CH_NUL);
                    run_b  = is_oper(i_ch);
                end else begin
                    do_wb = 1'b1;
                end
            end
            M_QUOTE: begin
                if (i_ch == CH_NUL) begin
                    res[n] = mk_res(KIND_ERROR, 8'd0, OP_PIPE, cur_idx(n_ts), ERR_QUOTE, 8'd0);
                    n      = n + 2'd1;
                    n_err  = ERR_QUOTE;
                    n_mode = M_SKIP;
                    do_le  = 1'b1;
                end else if (i_ch == (r_qc ? CH_DQ : CH_SQ)) begin
                    n_mode = M_WORD;
                end else begin
                    do_app = 1'b1;
                end
            end
            M_ESC: begin
                n_mode = M_WORD;
                do_app = 1'b1;
                if (i_ch == CH_NUL) begin
                    app_c = CH_BSL;
                    do_we = 1'b1;
                    do_le = 1'b1;
                end
            end
            M_GT: begin
                n_mode = M_BETWEEN;
                res[n] = mk_res(KIND_OPER, 8'd0, (i_ch == CH_GT) ? OP_APPEND : OP_OUT,
                                cur_idx(n_ts), ERR_NONE, 8'd0);
                n      = n + 2'd1;
                run_b  = (i_ch != CH_GT);
            end
            M_SKIP: begin
                do_le = (i_ch == CH_NUL);
            end
            default: begin
                n_mode = M_BETWEEN;
                run_b  = 1'b1;
            end
        endcase

        if (run_b) begin
            if (i_ch == CH_NUL) begin
                do_le = 1'b1;
            end else if (is_space(i_ch)) begin
                n_mode = n_mode;
            end else if (i_ch == CH_HASH) begin
                n_mode = M_SKIP;
            end else if (9'(n_ts) >= 9'(tok_lim)) begin
                res[n] = mk_res(KIND_ERROR, 8'd0, OP_PIPE, 7'(n_ts), ERR_TOO_MANY, 8'd0);
                n      = n + 2'd1;
                n_err  = ERR_TOO_MANY;
                n_mode = M_SKIP;
            end else begin
                n_ts = TS_W'(n_ts + 1'b1);
                if (i_ch == CH_GT) begin
                    n_mode = M_GT;
                end else if (is_oper(i_ch)) begin
                    res[n] = mk_res(KIND_OPER, 8'd0,
                                    (i_ch == CH_PIPE) ? OP_PIPE :
                                    ((i_ch == CH_LT) ? OP_IN : OP_BG),
                                    cur_idx(n_ts), ERR_NONE, 8'd0);
                    n      = n + 2'd1;
                end else begin
                    n_wl   = '0;
                    n_mode = M_WORD;
                    do_wb  = 1'b1;
                end
            end
        end

        if (do_wb) begin
            if (i_ch == CH_SQ || i_ch == CH_DQ) begin
                n_qc   = (i_ch == CH_DQ);
                n_mode = M_QUOTE;
            end else if (i_ch == CH_BSL) begin
                n_mode = M_ESC;
            end else begin
                do_app = 1'b1;
            end
        end

        if (do_app) begin
            if (9'(n_wl) >= 9'(len_lim)) begin
                res[n] = mk_res(KIND_ERROR, 8'd0, OP_PIPE, cur_idx(n_ts), ERR_TOO_LONG, 8'd0);
                n      = n + 2'd1;
                n_err  = ERR_TOO_LONG;
                n_mode = M_SKIP;
            end else begin
                n_wl   = WL_W'(n_wl + 1'b1);
                res[n] = mk_res(KIND_BYTE, app_c, OP_PIPE, cur_idx(n_ts), ERR_NONE, 8'd0);
                n      = n + 2'd1;
            end
        end

        if (do_we && n_mode == M_WORD) begin
            res[n] = mk_res(KIND_WORD_END, 8'd0, OP_PIPE, cur_idx(n_ts), ERR_NONE, 8'd0);
            n      = n + 2'd1;
            n_wl   = '0;
            n_mode = M_BETWEEN;
        end

        if (do_le) begin
            res[n] = mk_res(KIND_LINE_END, 8'd0, OP_PIPE, 7'd0, n_err, 8'(n_ts));
            n      = n + 2'd1;
            n_mode = M_BETWEEN;
            n_qc   = 1'b0;
            n_wl   = '0;
            n_ts   = '0;
            n_err  = ERR_NONE;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last = 1'b1;
        end

        o_batch.cnt = n;
        o_batch.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_qc   <= 1'b0;
            r_wl   <= '0;
            r_ts   <= '0;
            r_err  <= ERR_NONE;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_qc   <= n_qc;
            r_wl   <= n_wl;
            r_ts   <= n_ts;
            r_err  <= n_err;
        end
    end

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> (r_mode == M_SKIP))
        else $error("line error held outside skip mode");

    a_tokens_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'(r_ts) <= 9'(TOKEN_LIMIT))
        else $error("token count beyond limit");

endmodule
`default_nettype wire

// File: src/slt_resq.sv
`default_nettype none
module slt_resq
    import slt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_batch i_batch,
    input  wire logic   i_out_stall,
    output logic        o_room,
    output logic        o_valid,
    output t_res        o_res
);

    t_res       r_buf [3];
    logic [1:0] r_cnt;
    logic [1:0] r_rd;
    logic       take;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_buf[r_rd];
    assign take    = o_valid && !i_out_stall;
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_rd  <= 2'd0;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf[0] <= i_batch.res[0];
            r_buf[1] <= i_batch.res[1];
            r_buf[2] <= i_batch.res[2];
        end
    end

    a_load_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_room)
        else $error("batch loaded over pending results");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |-> (r_cnt == 2'd1))
        else $error("last flag on a result that is not the final one");

endmodule
`default_nettype wire

// File: src/shell_line_tokenizer.sv
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_ch
// out       source     o_out_valid / i_out_stall o_kind .. o_last
// cfg       sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// A byte passes an input register, is tokenized combinationally and its results
// (zero to three) land in a three-entry result buffer.
// One byte per cycle while the output is not stalled and each byte yields at most
// one result; a byte with more results holds the input while the buffer drains.
// An input beat reaches the output through the input register and then the result buffer.
// Reset is synchronous, active low; the limits return to 128 tokens and 255 bytes.
// A stall on the output holds the current result and backs up into o_in_stall.
module shell_line_tokenizer
    import slt_pkg::*;
#(
    parameter int TOKEN_LIMIT = 128,
    parameter int WORD_BUFFER = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_ch,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_char_value,
    output logic [2:0]      o_op_code,
    output logic [6:0]      o_token_index,
    output logic [1:0]      o_error_code,
    output logic [7:0]      o_token_count,
    output logic            o_last,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic [7:0] r_max_tokens;
    logic [7:0] r_max_word_len;
    logic       room, fire, accept;
    t_batch     batch;
    t_res       res;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tokens   <= 8'd128;
            r_max_word_len <= 8'd255;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_TOKENS) begin
                r_max_tokens <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAX_WORD_LEN) begin
                r_max_word_len <= i_cfg_data;
            end
        end
    end

    slt_lexer #(
        .TOKEN_LIMIT (TOKEN_LIMIT),
        .WORD_BUFFER (WORD_BUFFER)
    ) u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_ch           (r_in_ch),
        .i_max_tokens   (r_max_tokens),
        .i_max_word_len (r_max_word_len),
        .o_batch        (batch)
    );

    slt_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_batch     (batch),
        .i_out_stall (i_out_stall),
        .o_room      (room),
        .o_valid     (o_out_valid),
        .o_res       (res)
    );

    assign o_kind        = res.kind;
    assign o_char_value  = res.char_value;
    assign o_op_code     = res.op_code;
    assign o_token_index = res.token_index;
    assign o_error_code  = res.error_code;
    assign o_token_count = res.token_count;
    assign o_last        = res.last;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
    import slt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_CAP              = 128;
    localparam int WORD_CAP               = 255;
    localparam int CYCLE_LIMIT            = 400000;
    localparam int DRAIN_CYCLES           = 10;
    localparam int HOLD_CYCLES            = 250;
    localparam int RANDOM_BYTES_PER_PHASE = 45;
    localparam int BACKPRESSURE_BYTES     = 48;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_ch         = 8'h00;
    logic       i_out_stall  = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic       i_cfg_index  = CFG_MAX_TOKENS;
    logic [7:0] i_cfg_data   = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_kind;
    logic [7:0] o_char_value;
    logic [2:0] o_op_code;
    logic [6:0] o_token_index;
    logic [1:0] o_error_code;
    logic [7:0] o_token_count;
    logic       o_last;

    shell_line_tokenizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_ch          (i_ch),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_char_value  (o_char_value),
        .o_op_code     (o_op_code),
        .o_token_index (o_token_index),
        .o_error_code  (o_error_code),
        .o_token_count (o_token_count),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Tokenizer shadow state and limits
    logic [3:0] lx_mode      = M_BETWEEN;
    logic       lx_dq        = 1'b0;
    logic [7:0] lx_len       = 8'd0;
    logic [7:0] lx_tokens    = 8'd0;
    logic [1:0] lx_err       = ERR_NONE;
    logic [7:0] cfg_tokens   = 8'd128;
    logic [7:0] cfg_word_len = 8'd255;

    t_res step_res [3];
    int   step_n;
    t_res tok_result_q [$];

    logic [7:0] line_bytes [$];
    int   sent_bytes    = 0;
    int   fail_cnt      = 0;
    int   cycle_cnt     = 0;
    int   in_idle_pct   = 0;
    int   out_stall_pct = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;

    function automatic logic is_white(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP;
    endfunction

    function automatic logic [7:0] token_cap();
        logic [7:0] v;
        v = (cfg_tokens == 8'd0) ? 8'd1 : cfg_tokens;
        return (v > TOKEN_CAP) ? 8'(TOKEN_CAP) : v;
    endfunction

    function automatic logic [7:0] word_cap();
        logic [7:0] v;
        v = (cfg_word_len == 8'd0) ? 8'd1 : cfg_word_len;
        return (v > WORD_CAP) ? 8'(WORD_CAP) : v;
    endfunction

    function automatic logic [6:0] cur_idx();
        return (lx_tokens == 8'd0) ? 7'd0 : 7'(lx_tokens - 8'd1);
    endfunction

    function automatic void put_res(input logic [2:0] kind, input logic [7:0] chv,
                                    input logic [2:0] op, input logic [6:0] idx,
                                    input logic [1:0] err, input logic [7:0] cnt);
        if (step_n < 3) begin
            step_res[step_n] = '{kind, chv, op, idx, err, cnt, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void flag_lex_error(input logic [1:0] code, input logic [6:0] idx);
        put_res(KIND_ERROR, 8'd0, OP_PIPE, idx, code, 8'd0);
        lx_err  = code;
        lx_mode = M_SKIP;
    endfunction

    function automatic void close_line();
        put_res(KIND_LINE_END, 8'd0, OP_PIPE, 7'd0, lx_err, lx_tokens);
        lx_mode   = M_BETWEEN;
        lx_dq     = 1'b0;
        lx_len    = 8'd0;
        lx_tokens = 8'd0;
        lx_err    = ERR_NONE;
    endfunction

    function automatic void close_word();
        put_res(KIND_WORD_END, 8'd0, OP_PIPE, cur_idx(), ERR_NONE, 8'd0);
        lx_len  = 8'd0;
        lx_mode = M_BETWEEN;
    endfunction

    function automatic void append_byte(input logic [7:0] c);
        if (lx_len >= word_cap()) begin
            flag_lex_error(ERR_TOO_LONG, cur_idx());
        end else begin
            lx_len++;
            put_res(KIND_BYTE, c, OP_PIPE, cur_idx(), ERR_NONE, 8'd0);
        end
    endfunction

    function automatic void word_char(input logic [7:0] c);
        if (c == CH_SQ || c == CH_DQ) begin
            lx_dq   = (c == CH_DQ);
            lx_mode = M_QUOTE;
        end else if (c == CH_BSL) begin
            lx_mode = M_ESC;
        end else begin
            append_byte(c);
        end
    endfunction

    function automatic void start_token(input logic [7:0] c);
        logic [2:0] op;
        if (c == CH_NUL) begin
            close_line();
            return;
        end
        if (is_white(c))
            return;
        if (c == CH_HASH) begin
            lx_mode = M_SKIP;
            return;
        end
        if (lx_tokens >= token_cap()) begin
            flag_lex_error(ERR_TOO_MANY, lx_tokens[6:0]);
            return;
        end
        lx_tokens++;
        if (is_operator(c)) begin
            if (c == CH_GT) begin
                lx_mode = M_GT;
            end else begin
                op = (c == CH_PIPE) ? OP_PIPE : ((c == CH_LT) ? OP_IN : OP_BG);
                put_res(KIND_OPER, 8'd0, op, cur_idx(), ERR_NONE, 8'd0);
            end
            return;
        end
        lx_len  = 8'd0;
        lx_mode = M_WORD;
        word_char(c);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c);
        step_n = 0;
        case (lx_mode)
            M_WORD: begin
                if (c == CH_NUL) begin
                    close_word();
                    close_line();
                end else if (is_white(c)) begin
                    close_word();
                end else if (is_operator(c)) begin
                    close_word();
                    start_token(c);
                end else begin
                    word_char(c);
                end
            end
            M_QUOTE: begin
                if (c == CH_NUL) begin
                    flag_lex_error(ERR_QUOTE, cur_idx());
                    close_line();
                end else if (c == (lx_dq ? CH_DQ : CH_SQ)) begin
                    lx_mode = M_WORD;
                end else begin
                    append_byte(c);
                end
            end
            M_ESC: begin
                lx_mode = M_WORD;
                if (c == CH_NUL) begin
                    append_byte(CH_BSL);
                    if (lx_mode == M_WORD)
                        close_word();
                    close_line();
                end else begin
                    append_byte(c);
                end
            end
            M_GT: begin
                lx_mode = M_BETWEEN;
                if (c == CH_GT) begin
                    put_res(KIND_OPER, 8'd0, OP_APPEND, cur_idx(), ERR_NONE, 8'd0);
                end else begin
                    put_res(KIND_OPER, 8'd0, OP_OUT, cur_idx(), ERR_NONE, 8'd0);
                    start_token(c);
                end
            end
            M_SKIP: begin
                if (c == CH_NUL)
                    close_line();
            end
            default: begin
                lx_mode = M_BETWEEN;
                start_token(c);
            end
        endcase
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
        for (int k = 0; k < step_n; k++)
            tok_result_q.push_back(step_res[k]);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_result();
        t_res want;
        if (tok_result_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d", o_kind));
        end else begin
            want = tok_result_q.pop_front();
            check_field("kind", o_kind, want.kind);
            check_field("char_value", o_char_value, want.char_value);
            check_field("op_code", o_op_code, want.op_code);
            check_field("token_index", o_token_index, want.token_index);
            check_field("error_code", o_error_code, want.error_code);
            check_field("token_count", o_token_count, want.token_count);
            check_field("last", o_last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tokenize_byte(i_ch);
            if (o_out_valid && !i_out_stall)
                check_result();
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k]);
    endtask

    task automatic send_line();
        foreach (line_bytes[k])
            send_byte(line_bytes[k]);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tok_result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_limits(input logic [7:0] tokens, input logic [7:0] word_len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_TOKENS;
        i_cfg_data  <= tokens;
        @(posedge i_clk);
        cfg_tokens   = tokens;
        i_cfg_index <= CFG_MAX_WORD_LEN;
        i_cfg_data  <= word_len;
        @(posedge i_clk);
        cfg_word_len = word_len;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic is_special(input logic [7:0] c);
        return is_operator(c) || c == CH_SQ || c == CH_DQ || c == CH_BSL || c == CH_HASH;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255)); while (is_special(c));
        return c;
    endfunction

    function automatic logic [7:0] fill_char(input logic [7:0] closing);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == closing);
        return c;
    endfunction

    function automatic void push_word();
        int         segs;
        int         r;
        logic [7:0] q;
        segs = ($urandom_range(19) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        for (int s = 0; s < segs; s++) begin
            r = $urandom_range(99);
            if (r < 65 || (s == 0 && r < 70)) begin
                line_bytes.push_back(plain_char());
            end else if (r < 70) begin
                line_bytes.push_back(CH_HASH);
            end else if (r < 85) begin
                q = $urandom_range(1) ? CH_DQ : CH_SQ;
                line_bytes.push_back(q);
                repeat ($urandom_range(0, 3)) line_bytes.push_back(fill_char(q));
                line_bytes.push_back(q);
            end else begin
                line_bytes.push_back(CH_BSL);
                line_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    function automatic void push_oper();
        case ($urandom_range(4))
            0: line_bytes.push_back(CH_PIPE);
            1: line_bytes.push_back(CH_LT);
            2: line_bytes.push_back(CH_GT);
            3: begin
                line_bytes.push_back(CH_GT);
                line_bytes.push_back(CH_GT);
            end
            default: line_bytes.push_back(CH_AMP);
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Mostly well-formed lines with random content, the rest raw bytes
    function automatic void gen_line();
        int         ntok;
        int         r;
        logic [7:0] q;
        line_bytes.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            ntok = $urandom_range(1, 6);
            for (int k = 0; k < ntok; k++) begin
                if (k > 0 || $urandom_range(1))
                    repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
                r = $urandom_range(99);
                if (r < 60) begin
                    push_word();
                end else if (r < 90) begin
                    push_oper();
                end else begin
                    line_bytes.push_back(CH_HASH);
                    repeat ($urandom_range(0, 4))
                        line_bytes.push_back(8'($urandom_range(1, 255)));
                    break;
                end
            end
            r = $urandom_range(99);
            if (r < 6) begin
                line_bytes.push_back(CH_BSL);
            end else if (r < 12) begin
                q = $urandom_range(1) ? CH_DQ : CH_SQ;
                line_bytes.push_back(q);
                repeat ($urandom_range(0, 2)) line_bytes.push_back(fill_char(q));
            end
        end
        line_bytes.push_back(CH_NUL);
    endfunction

    function automatic logic [7:0] pick_token_limit();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd128;
            3: return 8'd255;
            default: return 8'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic logic [7:0] pick_word_limit();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd1;
            2, 3: return 8'd255;
            default: return 8'($urandom_range(2, 10));
        endcase
    endfunction

    task automatic test_lexing();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_text("a#");
        send_byte(CH_NUL);
        send_text("#x");
        send_byte(CH_NUL);
        send_text(">>|<&>x");
        send_byte(CH_NUL);
        send_text("\"\"");
        send_byte(CH_NUL);
        send_text("'a");
        send_byte(CH_NUL);
        send_text("\\");
        send_byte(CH_NUL);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_TAB);
        send_byte(CH_BSL);
        send_byte(8'hFF);
        send_byte(CH_SPACE);
        send_byte(CH_NUL);
        send_text(">");
        send_byte(CH_NUL);
        wait_idle();
    endtask

    task automatic test_limits();
        configure_limits(8'd1, 8'd255);
        send_text("a b");
        send_byte(CH_NUL);
        send_text("|x");
        send_byte(CH_NUL);
        wait_idle();
        configure_limits(8'd255, 8'd0);
        send_text("ab cd");
        send_byte(CH_NUL);
        send_text("'ab'");
        send_byte(CH_NUL);
        send_text("a\\");
        send_byte(CH_NUL);
        send_text("a\\b");
        send_byte(CH_NUL);
        wait_idle();
        configure_limits(8'd0, 8'd1);
        send_text("a|");
        send_byte(CH_NUL);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int first;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct   = 76;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 76;
                end
                default: begin
                    in_idle_pct   = 12;
                    out_stall_pct = 12;
                end
            endcase
            configure_limits(pick_token_limit(), pick_word_limit());
            first = sent_bytes;
            while (sent_bytes - first < RANDOM_BYTES_PER_PHASE) begin
                gen_line();
                send_line();
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        int first;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        configure_limits(8'd128, 8'd255);
        // hold the output while beats keep arriving
        hold_req = 1'b1;
        first    = sent_bytes;
        while (sent_bytes - first < BACKPRESSURE_BYTES) begin
            gen_line();
            send_line();
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_lexing();
        test_limits();
        test_random_traffic();
        test_backpressure();
        if (fail_cnt == 0 && tok_result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
